// ===== sv/bde_pkg.sv =====
package bde_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegInvertInput    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDebounceMs     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPressAckMs     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDelayOffMs     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongPressMs    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLongPressAckMs = 3'd5;

  localparam logic [MsW-1:0] DebounceMsRst     = 16'd50;
  localparam logic [MsW-1:0] PressAckMsRst     = 16'd100;
  localparam logic [MsW-1:0] DelayOffMsRst     = 16'd1000;
  localparam logic [MsW-1:0] LongPressMsRst    = 16'd1000;
  localparam logic [MsW-1:0] LongPressAckMsRst = 16'd100;

  // input sample, packed to match tdata low bits first
  typedef struct packed {
    logic [InDataW-37:0] pad;
    logic              clear_long_press;
    logic              raw_level;
    logic              long_press_enable;
    logic              enable_ctrl;
    logic [TimeW-1:0]  now_ms;
  } sample_t;

  typedef struct packed {
    logic [OutDataW-40:0] pad;
    logic [CountW-1:0] press_count;
    logic              long_press_ack;
    logic              long_pressed;
    logic              delayed_off;
    logic              toggle;
    logic              press_ack;
    logic              changed;
    logic              level;
  } result_t;

  typedef struct packed {
    logic             invert_input;
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   press_ack_ms;
    logic [MsW-1:0]   delay_off_ms;
    logic [MsW-1:0]   long_press_ms;
    logic [MsW-1:0]   long_press_ack_ms;
  } cfg_t;

  typedef struct packed {
    logic              stable_level;
    logic              previous_level;
    logic              change_flag;
    logic [TimeW-1:0]  last_change_time;
    logic [TimeW-1:0]  press_start_time;
    logic              ack_flag;
    logic              count_armed;
    logic [CountW-1:0] press_counter;
    logic              toggle_seen;
    logic              toggle_state;
    logic              delay_active;
    logic [TimeW-1:0]  delay_start_time;
    logic              delayed_flag;
    logic              long_latched;
    logic [TimeW-1:0]  long_start_time;
    logic              long_flag;
    logic [TimeW-1:0]  long_ack_start_time;
    logic              long_ack_flag;
  } state_t;

endpackage

// ===== sv/button_debounce_event_unit.sv =====
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   tdata: now_ms[31:0], enable_ctrl, long_press_enable, raw_level,
//                clear_long_press, zero fill to 40 bits
// m_axis    out  tdata: level, changed, press_ack, toggle, delayed_off,
//                long_pressed, long_press_ack, press_count[31:0], zero fill
// cfg       in   cfg_index (register 0..5), cfg_data (16 bits), always ready
//
// Throughput is one beat per cycle while the result is not stalled; an accepted
// input beat passes through the input register, then the result register.
// The step logic sits between the two registers: a handful of 32-bit
// subtract/compare paths against the stored timestamps.
// rst clears all control state and loads the register defaults.
// A stalled result blocks the input register only; one more beat is taken.
module button_debounce_event_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms, enable_ctrl, long_press_enable, raw_level, clear_long_press
  input  logic [bde_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // level, changed, press_ack, toggle, delayed_off, long_pressed,
  // long_press_ack, press_count
  output logic [bde_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bde_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bde_pkg::MsW-1:0]          cfg_data
);

  bde_pkg::cfg_t    cfg;
  bde_pkg::state_t  st, st_next;
  bde_pkg::sample_t smp;
  bde_pkg::result_t res_next;
  logic             smp_valid;
  logic             adv;

  // Step logic temporaries
  logic                        lvl;
  logic                        db_hold;
  logic                        stable_n;
  logic                        lf0, ll0;
  logic                        delay_start;
  logic [bde_pkg::TimeW-1:0]   now;
  logic [bde_pkg::TimeW-1:0]   dt_change, dt_press, dt_delay, dt_long, dt_lack;
  logic                        delay_done;

  assign cfg_ready     = 1'b1;
  assign adv           = smp_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !smp_valid || adv;

  always_comb begin
    st_next  = st;
    res_next = '0;
    now      = smp.now_ms;

    // clear request takes effect before the step
    lf0 = smp.clear_long_press ? 1'b0 : st.long_flag;
    ll0 = smp.clear_long_press ? 1'b0 : st.long_latched;

    lvl = (smp.raw_level && smp.enable_ctrl) ^ cfg.invert_input;

    // debounce
    dt_change = now - st.last_change_time;
    db_hold   = dt_change < {16'd0, cfg.debounce_ms};
    if (db_hold) begin
      st_next.change_flag = 1'b0;
    end else begin
      st_next.previous_level = st.stable_level;
      st_next.stable_level   = lvl;
      st_next.change_flag    = lvl != st.stable_level;
      if (lvl != st.stable_level) begin
        st_next.last_change_time = now;
      end
    end
    stable_n = st_next.stable_level;

    // press acknowledge; while held the start time is the stored one
    dt_press = now - st.press_start_time;
    if (!stable_n) begin
      st_next.press_start_time = now;
    end
    st_next.ack_flag = stable_n && (dt_press <= {16'd0, cfg.press_ack_ms});

    // press counter
    if (stable_n) begin
      if (!st.count_armed) begin
        st_next.press_counter = st.press_counter + 1'b1;
        st_next.count_armed   = 1'b1;
      end
    end else begin
      st_next.count_armed = 1'b0;
    end

    // toggle
    if (stable_n && smp.enable_ctrl) begin
      if (!st.toggle_seen) begin
        st_next.toggle_seen  = 1'b1;
        st_next.toggle_state = !st.toggle_state;
      end
    end else begin
      st_next.toggle_seen = 1'b0;
    end
    if (!smp.enable_ctrl) begin
      st_next.toggle_state = 1'b0;
    end

    // delayed off; a fresh start has zero elapsed time
    delay_start = !st.delay_active && stable_n && smp.enable_ctrl;
    dt_delay    = delay_start ? '0 : (now - st.delay_start_time);
    if (delay_start) begin
      st_next.delay_active     = 1'b1;
      st_next.delay_start_time = now;
      st_next.delayed_flag     = 1'b1;
    end
    delay_done = dt_delay >= {16'd0, cfg.delay_off_ms};
    if (st_next.delay_active && delay_done) begin
      st_next.delayed_flag = 1'b0;
      if (!stable_n || !smp.enable_ctrl) begin
        st_next.delay_active = 1'b0;
      end
    end
    if (!smp.enable_ctrl) begin
      st_next.delayed_flag = 1'b0;
      st_next.delay_active = 1'b0;
    end

    // long press
    st_next.long_flag    = lf0;
    st_next.long_latched = ll0;
    dt_long = now - st.long_start_time;
    if (stable_n && !ll0) begin
      st_next.long_flag = 1'b0;
      if ((dt_long > {16'd0, cfg.long_press_ms}) && smp.long_press_enable) begin
        st_next.long_flag    = 1'b1;
        st_next.long_latched = 1'b1;
      end
    end else begin
      st_next.long_start_time = now;
    end
    if (!stable_n) begin
      st_next.long_latched = 1'b0;
    end
    if (!smp.enable_ctrl) begin
      st_next.long_flag    = 1'b0;
      st_next.long_latched = 1'b0;
    end

    // long press acknowledge; while flagged the start time is the stored one
    dt_lack = now - st.long_ack_start_time;
    if (!st_next.long_flag) begin
      st_next.long_ack_start_time = now;
    end
    st_next.long_ack_flag = st_next.long_flag &&
                            (dt_lack <= {16'd0, cfg.long_press_ack_ms});

    res_next.level          = st_next.stable_level;
    res_next.changed        = st_next.change_flag;
    res_next.press_ack      = st_next.ack_flag;
    res_next.toggle         = st_next.toggle_state;
    res_next.delayed_off    = st_next.delayed_flag;
    res_next.long_pressed   = st_next.long_flag;
    res_next.long_press_ack = st_next.long_ack_flag;
    res_next.press_count    = st_next.press_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_input      <= 1'b0;
      cfg.debounce_ms       <= bde_pkg::DebounceMsRst;
      cfg.press_ack_ms      <= bde_pkg::PressAckMsRst;
      cfg.delay_off_ms      <= bde_pkg::DelayOffMsRst;
      cfg.long_press_ms     <= bde_pkg::LongPressMsRst;
      cfg.long_press_ack_ms <= bde_pkg::LongPressAckMsRst;
      st            <= '0;
      smp_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bde_pkg::RegInvertInput:    cfg.invert_input      <= cfg_data[0];
          bde_pkg::RegDebounceMs:     cfg.debounce_ms       <= cfg_data;
          bde_pkg::RegPressAckMs:     cfg.press_ack_ms      <= cfg_data;
          bde_pkg::RegDelayOffMs:     cfg.delay_off_ms      <= cfg_data;
          bde_pkg::RegLongPressMs:    cfg.long_press_ms     <= cfg_data;
          bde_pkg::RegLongPressAckMs: cfg.long_press_ack_ms <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tready) begin
        smp_valid <= s_axis_tvalid;
      end
      if (adv) begin
        st            <= st_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      smp <= bde_pkg::sample_t'(s_axis_tdata);
    end
    if (adv) begin
      m_axis_tdata <= res_next;
    end
  end

  bde_pkg::result_t out_res;
  assign out_res = bde_pkg::result_t'(m_axis_tdata);

  // a step always lands in the result register
  a_adv_loads: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_axis_tvalid)
    else $error("step result not loaded");

  // counter moves by at most one per step
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (st.press_counter - $past(st.press_counter)) <= 32'd1)
    else $error("press counter jumped");

  // disabled sample clears toggle, delayed-off and long press
  a_ctrl_clears: assert property (@(posedge clk) disable iff (rst)
    adv && !smp.enable_ctrl |=>
      !out_res.toggle && !out_res.delayed_off && !out_res.long_pressed)
    else $error("disable did not clear outputs");

  // long press acknowledge only with long press
  a_lack_needs_long: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!out_res.long_press_ack || out_res.long_pressed))
    else $error("long press ack without long press");

endmodule
